/* hdl/cdq_pkg.sv */
// shared types and codes for the circular deque
package cdq_pkg;

    // fixed widths of the data words and codes
    localparam int WORD_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // operation codes carried in the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } opcode_t;

    // result codes carried in the output tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // memory command from the index control to the slot store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_cmd_t;

endpackage

/* hdl/cdq_store.sv */
// slot store: single-port synchronous memory with registered read data
module cdq_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                        clk,
    input  cdq_pkg::mem_cmd_t           cmd,
    input  logic [AW-1:0]               addr,
    input  logic [cdq_pkg::WORD_W-1:0]  wr_data,
    output logic [cdq_pkg::WORD_W-1:0]  rd_data
);

    logic [cdq_pkg::WORD_W-1:0] mem [DEPTH];
    logic [cdq_pkg::WORD_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    // read port, registered, held until the next read
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/cdq_ctrl.sv */
// index control: front, rear and empty flag, memory commands and result register
module cdq_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [cdq_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [cdq_pkg::WORD_W-1:0]    m_axis_tdata,
    output logic [cdq_pkg::STATUS_W-1:0]  m_axis_tuser,
    output cdq_pkg::mem_cmd_t             cmd,
    output logic [AW-1:0]                 addr,
    input  logic [cdq_pkg::WORD_W-1:0]    rd_data
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0]    front_reg, front_next;
    logic [AW-1:0]    rear_reg, rear_next;
    logic             empty_reg, empty_next;
    logic             out_valid_reg, out_valid_next;
    cdq_pkg::status_t status_reg, status_next;
    logic             from_mem_reg, from_mem_next;

    logic             accept;
    cdq_pkg::opcode_t op;
    logic [AW-1:0]    front_inc, front_dec, rear_inc, rear_dec;
    logic             full;

    assign op     = cdq_pkg::opcode_t'(s_axis_tuser);
    assign accept = s_axis_tvalid && s_axis_tready;

    // a new transfer is taken whenever the result register frees up
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    // wrapping neighbours of the indices
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign rear_inc  = (rear_reg == LAST_IDX) ? '0 : rear_reg + 1'b1;
    assign rear_dec  = (rear_reg == '0) ? LAST_IDX : rear_reg - 1'b1;
    assign full      = !empty_reg && (rear_inc == front_reg);

    // index update, memory access and result code
    always_comb
    begin
        front_next    = front_reg;
        rear_next     = rear_reg;
        empty_next    = empty_reg;
        status_next   = status_reg;
        from_mem_next = from_mem_reg;
        cmd           = '0;
        addr          = '0;
        if (accept)
        begin
            status_next   = cdq_pkg::ST_DONE;
            from_mem_next = 1'b0;
            case (op)
                cdq_pkg::OP_PUSH_FRONT,
                cdq_pkg::OP_PUSH_REAR:
                begin
                    if (full)
                    begin
                        status_next = cdq_pkg::ST_FULL;
                    end
                    else if (empty_reg)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                        empty_next = 1'b0;
                        cmd.wr_en  = 1'b1;
                        addr       = '0;
                    end
                    else if (op == cdq_pkg::OP_PUSH_FRONT)
                    begin
                        front_next = front_dec;
                        cmd.wr_en  = 1'b1;
                        addr       = front_dec;
                    end
                    else
                    begin
                        rear_next = rear_inc;
                        cmd.wr_en = 1'b1;
                        addr      = rear_inc;
                    end
                end
                default:
                begin
                    if (empty_reg)
                    begin
                        status_next = cdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd.rd_en     = 1'b1;
                        from_mem_next = 1'b1;
                        addr = (op == cdq_pkg::OP_POP_FRONT) ? front_reg : rear_reg;
                        if (front_reg == rear_reg)
                        begin
                            empty_next = 1'b1;
                            front_next = '0;
                            rear_next  = '0;
                        end
                        else if (op == cdq_pkg::OP_POP_FRONT)
                        begin
                            front_next = front_inc;
                        end
                        else
                        begin
                            rear_next = rear_dec;
                        end
                    end
                end
            endcase
        end
    end

    // result register valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            rear_reg      <= '0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        from_mem_reg <= from_mem_next;
    end

    // popped word comes straight from the memory read register
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = from_mem_reg ? rd_data : '0;
    assign m_axis_tuser  = status_reg;

`ifndef SYNTHESIS
    // an empty deque keeps both indices at slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (front_reg == '0) && (rear_reg == '0))
        else $error("empty deque with non-zero index");

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("transfer accepted over a stalled result");

    // a pop on an empty deque reports empty and returns zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && empty_reg && (op == cdq_pkg::OP_POP_FRONT || op == cdq_pkg::OP_POP_REAR))
        |=> (status_reg == cdq_pkg::ST_EMPTY) && (m_axis_tdata == '0))
        else $error("pop on empty not flagged");

    // a push into an empty deque leaves it non-empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && empty_reg && (op == cdq_pkg::OP_PUSH_FRONT || op == cdq_pkg::OP_PUSH_REAR))
        |=> !empty_reg && (status_reg == cdq_pkg::ST_DONE))
        else $error("push into empty deque lost");
`endif

endmodule

/* hdl/circular_deque.sv */
// top level of the circular double-ended queue
//
//  port group  dir  tdata                 tuser
//  s_axis      in   push_value [31:0]     opcode [1:0]
//  m_axis      out  pop_value  [31:0]     status [1:0]
//
// one transfer per cycle while no result is stalled: each operation updates the
// indices in the cycle it is taken and issues at most one access to the slot store,
// whose read data arrives in the next cycle as the result. reset clears the indices
// and marks the deque empty; slot contents are left as they are. a stalled result
// holds s_axis_tready low, since the result lives in the store's read register.
module circular_deque #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [cdq_pkg::WORD_W-1:0]    s_axis_tdata,   // push_value
    input  logic [cdq_pkg::OP_W-1:0]      s_axis_tuser,   // opcode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [cdq_pkg::WORD_W-1:0]    m_axis_tdata,   // pop_value
    output logic [cdq_pkg::STATUS_W-1:0]  m_axis_tuser    // status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cdq_pkg::mem_cmd_t          cmd;
    logic [AW-1:0]              addr;
    logic [cdq_pkg::WORD_W-1:0] rd_data;

    // index control and result register
    cdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .addr          (addr),
        .rd_data       (rd_data)
    );

    // slot memory
    cdq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .cmd     (cmd),
        .addr    (addr),
        .wr_data (s_axis_tdata),
        .rd_data (rd_data)
    );

endmodule
